@@ rtl/cpos_pkg.sv @@
// Shared constants for the closest-point-on-segment pipeline.
package cpos_pkg;

    // Default coordinate width (signed fixed point, any fraction split)
    localparam int COORD_WIDTH_DEF = 32;

    // Segment parameter t: unsigned Q1.16
    localparam int T_BITS = 16;
    localparam int T_W    = T_BITS + 1;
    localparam logic [T_W-1:0] T_ZERO = '0;
    localparam logic [T_W-1:0] T_ONE  = T_W'(1) << T_BITS;

endpackage

@@ rtl/cpos_req_if.sv @@
// Request channel: segment start, segment end and query point.
interface cpos_req_if #(
    parameter int COORD_WIDTH = cpos_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] start_z;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic signed [COORD_WIDTH-1:0] end_z;
    logic signed [COORD_WIDTH-1:0] query_x;
    logic signed [COORD_WIDTH-1:0] query_y;
    logic signed [COORD_WIDTH-1:0] query_z;

    modport source (
        output valid, start_x, start_y, start_z, end_x, end_y, end_z,
               query_x, query_y, query_z,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
               query_x, query_y, query_z,
        output ready
    );
endinterface

@@ rtl/cpos_res_if.sv @@
// Result channel: nearest point, clamped t and degenerate flag.
interface cpos_res_if #(
    parameter int COORD_WIDTH = cpos_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] nearest_x;
    logic signed [COORD_WIDTH-1:0] nearest_y;
    logic signed [COORD_WIDTH-1:0] nearest_z;
    logic [cpos_pkg::T_W-1:0]      param_t;
    logic                          degenerate;

    modport source (
        output valid, nearest_x, nearest_y, nearest_z, param_t, degenerate,
        input  ready
    );
    modport sink (
        input  valid, nearest_x, nearest_y, nearest_z, param_t, degenerate,
        output ready
    );
endinterface

@@ rtl/cpos_dot.sv @@
// Front end: differences, six products and the two dot products (3 stages).
module cpos_dot #(
    parameter int W = cpos_pkg::COORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0][W-1:0]    i_start,
    input  logic [2:0][W-1:0]    i_end,
    input  logic [2:0][W-1:0]    i_query,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2*W+2:0]       o_num,
    output logic [2*W+2:0]       o_den,
    output logic [2:0][W-1:0]    o_start,
    output logic [2:0][W-1:0]    o_lmag,
    output logic [2:0]           o_lneg
);
    localparam int PW = 2 * W + 2;   // one product
    localparam int NW = 2 * W + 3;   // sum of three products

    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    logic [2:0][W:0]    r_line1, r_rel1, n_line1, n_rel1;
    logic [2:0][W-1:0]  r_s1, r_s2, r_s3;
    logic [2:0][PW-1:0] r_pll, r_plr, n_pll, n_plr;
    logic [2:0][W:0]    line_neg;
    logic [2:0][W-1:0]  r_lmag2, r_lmag3, n_lmag2;
    logic [2:0]         r_lneg2, r_lneg3;
    logic [NW-1:0]      r_num3, r_den3, n_num3, n_den3;

    // Stage enables: a stage moves when empty or when the next one moves
    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // Stage 1: line = end - start, rel = query - start (one extra bit)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_line1[i] = {i_end[i][W-1], i_end[i]} - {i_start[i][W-1], i_start[i]};
            n_rel1[i]  = {i_query[i][W-1], i_query[i]} - {i_start[i][W-1], i_start[i]};
        end
    end

    // Stage 2: signed products and line magnitude
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_pll[i]    = $signed(r_line1[i]) * $signed(r_line1[i]);
            n_plr[i]    = $signed(r_line1[i]) * $signed(r_rel1[i]);
            line_neg[i] = ~r_line1[i] + 1'b1;
            n_lmag2[i]  = r_line1[i][W] ? line_neg[i][W-1:0] : r_line1[i][W-1:0];
        end
    end

    // Stage 3: three-term sums
    always_comb begin
        n_num3 = {r_plr[0][PW-1], r_plr[0]} + {r_plr[1][PW-1], r_plr[1]}
               + {r_plr[2][PW-1], r_plr[2]};
        n_den3 = {r_pll[0][PW-1], r_pll[0]} + {r_pll[1][PW-1], r_pll[1]}
               + {r_pll[2][PW-1], r_pll[2]};
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_line1 <= n_line1;
            r_rel1  <= n_rel1;
            r_s1    <= i_start;
        end
        if (en2) begin
            r_pll   <= n_pll;
            r_plr   <= n_plr;
            r_lmag2 <= n_lmag2;
            for (int i = 0; i < 3; i++) r_lneg2[i] <= r_line1[i][W];
            r_s2    <= r_s1;
        end
        if (en3) begin
            r_num3  <= n_num3;
            r_den3  <= n_den3;
            r_lmag3 <= r_lmag2;
            r_lneg3 <= r_lneg2;
            r_s3    <= r_s2;
        end
    end

    assign o_valid = r_v3;
    assign o_num   = r_num3;
    assign o_den   = r_den3;
    assign o_start = r_s3;
    assign o_lmag  = r_lmag3;
    assign o_lneg  = r_lneg3;

`ifndef ASSERT_OFF
    // Sum of squares can never come out negative
    a_den_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> !r_den3[NW-1])
        else $error("cpos_dot: negative denominator");

    // Zero-length segment must give a zero numerator
    a_zero_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_den3 == '0) |-> (r_num3 == '0))
        else $error("cpos_dot: nonzero numerator on zero-length segment");
`endif

endmodule

@@ rtl/cpos_div.sv @@
// Clamp decision and restoring divider, one quotient bit per stage.
module cpos_div #(
    parameter int W = cpos_pkg::COORD_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [2*W+2:0]             i_num,
    input  logic [2*W+2:0]             i_den,
    input  logic [2:0][W-1:0]          i_start,
    input  logic [2:0][W-1:0]          i_lmag,
    input  logic [2:0]                 i_lneg,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [cpos_pkg::T_W-1:0]   o_t,
    output logic                       o_degen,
    output logic [2:0][W-1:0]          o_start,
    output logic [2:0][W-1:0]          o_lmag,
    output logic [2:0]                 o_lneg
);
    localparam int NW = 2 * W + 3;          // signed dot product width
    localparam int RW = 2 * W + 2;          // denominator and remainder width
    localparam int NS = cpos_pkg::T_BITS + 1;  // decision stage + one per bit
    localparam int TW = cpos_pkg::T_W;

    logic                r_v     [0:NS-1];
    logic                en      [0:NS-1];
    logic [RW-1:0]       r_rem   [0:NS-1];
    logic [RW-1:0]       r_den   [0:NS-1];
    logic [TW-1:0]       r_q     [0:NS-1];
    logic                r_run   [0:NS-1];
    logic                r_degen [0:NS-1];
    logic [2:0][W-1:0]   r_start [0:NS-1];
    logic [2:0][W-1:0]   r_lmag  [0:NS-1];
    logic [2:0]          r_lneg  [0:NS-1];

    logic          degen, num_pos, num_ge;
    logic [TW-1:0] n_q0;
    logic          n_run0;

    // Enable chain, last stage faces the scaler
    assign en[NS-1] = !r_v[NS-1] || i_ready;
    generate
        for (genvar k = 0; k < NS - 1; k++) begin : g_en
            assign en[k] = !r_v[k] || en[k+1];
        end
    endgenerate
    assign o_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_v[k] <= 1'b0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // Decision stage: degenerate, behind start, beyond end, or divide
    always_comb begin
        degen   = (i_den == '0);
        num_pos = !i_num[NW-1] && (i_num != '0);
        num_ge  = (i_num >= i_den);
        n_q0    = cpos_pkg::T_ZERO;
        n_run0  = 1'b0;
        if (!degen && num_pos) begin
            if (num_ge) begin
                n_q0 = cpos_pkg::T_ONE;
            end else begin
                n_run0 = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_rem[0]   <= i_num[RW-1:0];
            r_den[0]   <= i_den[RW-1:0];
            r_q[0]     <= n_q0;
            r_run[0]   <= n_run0;
            r_degen[0] <= degen;
            r_start[0] <= i_start;
            r_lmag[0]  <= i_lmag;
            r_lneg[0]  <= i_lneg;
        end
    end

    // Divide stages: shift, compare, subtract
    generate
        for (genvar k = 1; k < NS; k++) begin : g_step
            logic [RW:0]   rem2, diff;
            logic          ge;
            logic [RW-1:0] n_rem;
            logic [TW-1:0] n_q;

            always_comb begin
                rem2  = {r_rem[k-1], 1'b0};
                ge    = (rem2 >= {1'b0, r_den[k-1]});
                diff  = rem2 - {1'b0, r_den[k-1]};
                n_rem = ge ? diff[RW-1:0] : rem2[RW-1:0];
                n_q   = r_run[k-1] ? {r_q[k-1][TW-2:0], ge} : r_q[k-1];
            end

            always_ff @(posedge i_clk) begin
                if (en[k]) begin
                    r_rem[k]   <= n_rem;
                    r_den[k]   <= r_den[k-1];
                    r_q[k]     <= n_q;
                    r_run[k]   <= r_run[k-1];
                    r_degen[k] <= r_degen[k-1];
                    r_start[k] <= r_start[k-1];
                    r_lmag[k]  <= r_lmag[k-1];
                    r_lneg[k]  <= r_lneg[k-1];
                end
            end
        end
    endgenerate

    assign o_valid = r_v[NS-1];
    assign o_t     = r_q[NS-1];
    assign o_degen = r_degen[NS-1];
    assign o_start = r_start[NS-1];
    assign o_lmag  = r_lmag[NS-1];
    assign o_lneg  = r_lneg[NS-1];

`ifndef ASSERT_OFF
    // Clamped t never exceeds one
    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS-1] |-> (r_q[NS-1] <= cpos_pkg::T_ONE))
        else $error("cpos_div: t above one");

    // Degenerate segment leaves t at zero
    a_degen_t: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS-1] && r_degen[NS-1]) |-> (r_q[NS-1] == cpos_pkg::T_ZERO))
        else $error("cpos_div: degenerate segment with nonzero t");
`endif

endmodule

@@ rtl/cpos_scale.sv @@
// Back end: offset = trunc(line * t), nearest = start + offset (2 stages).
module cpos_scale #(
    parameter int W = cpos_pkg::COORD_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [cpos_pkg::T_W-1:0]   i_t,
    input  logic                       i_degen,
    input  logic [2:0][W-1:0]          i_start,
    input  logic [2:0][W-1:0]          i_lmag,
    input  logic [2:0]                 i_lneg,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [2:0][W-1:0]          o_nearest,
    output logic [cpos_pkg::T_W-1:0]   o_t,
    output logic                       o_degen
);
    localparam int TW = cpos_pkg::T_W;
    localparam int PW = W + TW;

    logic              r_va, r_vb, en_a, en_b;
    logic [2:0][PW-1:0] r_prod, n_prod;
    logic [2:0][W-1:0] r_sa, off, off_neg, n_near, r_near;
    logic [2:0]        r_nega;
    logic [TW-1:0]     r_ta, r_tb;
    logic              r_dga, r_dgb;

    assign en_b    = !r_vb || i_ready;
    assign en_a    = !r_va || en_b;
    assign o_ready = en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (en_a) r_va <= i_valid;
            if (en_b) r_vb <= r_va;
        end
    end

    // Stage A: magnitude times t
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_prod[i] = {{TW{1'b0}}, i_lmag[i]} * {{W{1'b0}}, i_t};
        end
    end

    // Stage B: drop fraction of t, restore sign, add start
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            off[i]     = r_prod[i][W+cpos_pkg::T_BITS-1:cpos_pkg::T_BITS];
            off_neg[i] = ~off[i] + 1'b1;
            n_near[i]  = r_sa[i] + (r_nega[i] ? off_neg[i] : off[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_prod <= n_prod;
            r_sa   <= i_start;
            r_nega <= i_lneg;
            r_ta   <= i_t;
            r_dga  <= i_degen;
        end
        if (en_b) begin
            r_near <= n_near;
            r_tb   <= r_ta;
            r_dgb  <= r_dga;
        end
    end

    assign o_valid   = r_vb;
    assign o_nearest = r_near;
    assign o_t       = r_tb;
    assign o_degen   = r_dgb;

`ifndef ASSERT_OFF
    // Offset never exceeds the line magnitude, so it fits in W bits
    a_off_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_va |-> (r_prod[0][PW-1:W+cpos_pkg::T_BITS] == '0
                  && r_prod[1][PW-1:W+cpos_pkg::T_BITS] == '0
                  && r_prod[2][PW-1:W+cpos_pkg::T_BITS] == '0))
        else $error("cpos_scale: offset out of range");
`endif

endmodule

@@ rtl/closest_point_on_segment_unit.sv @@
// Top level of the closest-point-on-segment unit.
// Finds the point of segment [start, end] nearest to a query point, all in signed
// fixed point of COORD_WIDTH bits (any fraction split; the result keeps the input
// format). t = dot(line, rel) / dot(line, line) is clamped to [0, 1] and reported
// as unsigned Q1.16 (65536 is one), truncated toward zero; the point is
// start + trunc(line * t). A zero-length segment returns start with t zero and
// degenerate set. Throughput is one request per clock while the output is not stalled;
// from acceptance to result valid a request passes 3 stages of differences, products and dot sums,
// one clamp-decision stage, 16 divider stages (one quotient bit each), and 2
// stages of scaling and add. Each stage holds its own valid bit, so a stalled
// output lets empty stages upstream keep filling.
module closest_point_on_segment_unit #(
    parameter int COORD_WIDTH = cpos_pkg::COORD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cpos_req_if.sink    i_req,
    cpos_res_if.source  o_res
);
    localparam int W  = COORD_WIDTH;
    localparam int NW = 2 * W + 3;
    localparam int TW = cpos_pkg::T_W;

    logic [2:0][W-1:0] req_start, req_end, req_query;

    logic              dot_valid, dot_ready;
    logic [NW-1:0]     dot_num, dot_den;
    logic [2:0][W-1:0] dot_start, dot_lmag;
    logic [2:0]        dot_lneg;

    logic              div_valid, div_ready;
    logic [TW-1:0]     div_t;
    logic              div_degen;
    logic [2:0][W-1:0] div_start, div_lmag;
    logic [2:0]        div_lneg;

    logic [2:0][W-1:0] res_nearest;

    // Request fields into x/y/z lanes
    assign req_start = {i_req.start_z, i_req.start_y, i_req.start_x};
    assign req_end   = {i_req.end_z,   i_req.end_y,   i_req.end_x};
    assign req_query = {i_req.query_z, i_req.query_y, i_req.query_x};

    cpos_dot #(.W(W)) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_start (req_start),
        .i_end   (req_end),
        .i_query (req_query),
        .o_valid (dot_valid),
        .i_ready (dot_ready),
        .o_num   (dot_num),
        .o_den   (dot_den),
        .o_start (dot_start),
        .o_lmag  (dot_lmag),
        .o_lneg  (dot_lneg)
    );

    cpos_div #(.W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dot_valid),
        .o_ready (dot_ready),
        .i_num   (dot_num),
        .i_den   (dot_den),
        .i_start (dot_start),
        .i_lmag  (dot_lmag),
        .i_lneg  (dot_lneg),
        .o_valid (div_valid),
        .i_ready (div_ready),
        .o_t     (div_t),
        .o_degen (div_degen),
        .o_start (div_start),
        .o_lmag  (div_lmag),
        .o_lneg  (div_lneg)
    );

    cpos_scale #(.W(W)) u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (div_valid),
        .o_ready   (div_ready),
        .i_t       (div_t),
        .i_degen   (div_degen),
        .i_start   (div_start),
        .i_lmag    (div_lmag),
        .i_lneg    (div_lneg),
        .o_valid   (o_res.valid),
        .i_ready   (o_res.ready),
        .o_nearest (res_nearest),
        .o_t       (o_res.param_t),
        .o_degen   (o_res.degenerate)
    );

    assign o_res.nearest_x = res_nearest[0];
    assign o_res.nearest_y = res_nearest[1];
    assign o_res.nearest_z = res_nearest[2];

`ifndef ASSERT_OFF
    // A degenerate result sits exactly at start, so t must read zero
    a_out_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.degenerate) |-> (o_res.param_t == cpos_pkg::T_ZERO))
        else $error("closest_point_on_segment_unit: degenerate with nonzero t");
`endif

endmodule

@@ sim/closest_point_on_segment_unit_tb.sv @@
// Self-checking testbench for the closest-point-on-segment unit.
module closest_point_on_segment_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW          = cpos_pkg::COORD_WIDTH_DEF;
    localparam int CLK_PERIOD  = 8;
    localparam int RST_CYCLES  = 9;
    localparam int RAND_SEGS   = 450;
    localparam int PHASE1_AT   = 160;
    localparam int PHASE2_AT   = 320;
    localparam int HOLD_AT     = 30;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS = 10;
    localparam int ONE_Q       = 65536;
    localparam longint TIMEOUT_NS = 2_000_000;

    typedef logic [CW-1:0] coord_t;

    localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};

    typedef struct packed {
        coord_t start_x, start_y, start_z;
        coord_t end_x, end_y, end_z;
        coord_t query_x, query_y, query_z;
    } seg_req_t;

    typedef struct packed {
        coord_t                   nearest_x, nearest_y, nearest_z;
        logic [cpos_pkg::T_W-1:0] param_t;
        logic                     degenerate;
    } seg_res_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cpos_req_if #(.COORD_WIDTH(CW)) req_if ();
    cpos_res_if #(.COORD_WIDTH(CW)) res_if ();

    closest_point_on_segment_unit #(.COORD_WIDTH(CW)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    seg_req_t seg_pending[$];
    seg_res_t nearest_expected[$];
    int       seg_sent     = 0;
    int       nearest_seen = 0;
    int       mismatch_cnt = 0;
    logic     req_taken    = 1'b0;
    logic     hold_on      = 1'b0;
    logic     hold_done    = 1'b0;
    int       hold_left    = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Expected answer: clamped projection of the query onto the segment
    function automatic seg_res_t nearest_on_segment(input seg_req_t r);
        longint              base [3];
        longint              line [3];
        longint              rel  [3];
        longint              near [3];
        logic signed [127:0] lw, rw, num, den, quo;
        longint              t_q;
        seg_res_t            res;
        base[0] = $signed(r.start_x);
        base[1] = $signed(r.start_y);
        base[2] = $signed(r.start_z);
        line[0] = longint'($signed(r.end_x)) - base[0];
        line[1] = longint'($signed(r.end_y)) - base[1];
        line[2] = longint'($signed(r.end_z)) - base[2];
        rel[0]  = longint'($signed(r.query_x)) - base[0];
        rel[1]  = longint'($signed(r.query_y)) - base[1];
        rel[2]  = longint'($signed(r.query_z)) - base[2];
        num = 0;
        den = 0;
        for (int i = 0; i < 3; i++) begin
            lw  = line[i];
            rw  = rel[i];
            num = num + lw * rw;
            den = den + lw * lw;
        end
        res.degenerate = (den == 0);
        if (res.degenerate || num <= 0) begin
            t_q = 0;
        end else if (num >= den) begin
            t_q = cpos_pkg::T_ONE;
        end else begin
            quo = (num <<< cpos_pkg::T_BITS) / den;
            t_q = longint'(quo);
        end
        // signed division truncates toward zero, as the offset must
        for (int i = 0; i < 3; i++)
            near[i] = base[i] + (line[i] * t_q) / (longint'(1) << cpos_pkg::T_BITS);
        res.nearest_x = near[0][CW-1:0];
        res.nearest_y = near[1][CW-1:0];
        res.nearest_z = near[2][CW-1:0];
        res.param_t   = t_q[cpos_pkg::T_W-1:0];
        return res;
    endfunction

    function automatic int send_idle_pct(input int n);
        if (n < PHASE1_AT) return 20;
        if (n < PHASE2_AT) return 65;
        return 0;
    endfunction

    function automatic int recv_idle_pct(input int n);
        if (n < PHASE1_AT) return 65;
        if (n < PHASE2_AT) return 20;
        return 0;
    endfunction

    function automatic coord_t pick_special();
        case ($urandom_range(6))
            0: return C_MIN;
            1: return C_MAX;
            2: return '0;
            3: return '1;
            4: return coord_t'(1);
            5: return coord_t'(ONE_Q);
            default: return coord_t'(-ONE_Q);
        endcase
    endfunction

    task automatic queue_seg(input coord_t sx, sy, sz, ex, ey, ez, qx, qy, qz);
        seg_req_t r;
        r = '{sx, sy, sz, ex, ey, ez, qx, qy, qz};
        seg_pending.push_back(r);
    endtask

    // Request driver: new data at the falling edge, held until accepted
    always @(negedge i_clk) begin
        seg_req_t nxt;
        if (!i_rst_n) begin
            req_if.valid   <= 1'b0;
            req_if.start_x <= '0;
            req_if.start_y <= '0;
            req_if.start_z <= '0;
            req_if.end_x   <= '0;
            req_if.end_y   <= '0;
            req_if.end_z   <= '0;
            req_if.query_x <= '0;
            req_if.query_y <= '0;
            req_if.query_z <= '0;
        end else if (!req_if.valid || req_taken) begin
            if (seg_pending.size() != 0 &&
                $urandom_range(99) >= send_idle_pct(seg_sent)) begin
                nxt = seg_pending.pop_front();
                req_if.valid   <= 1'b1;
                req_if.start_x <= nxt.start_x;
                req_if.start_y <= nxt.start_y;
                req_if.start_z <= nxt.start_z;
                req_if.end_x   <= nxt.end_x;
                req_if.end_y   <= nxt.end_y;
                req_if.end_z   <= nxt.end_z;
                req_if.query_x <= nxt.query_x;
                req_if.query_y <= nxt.query_y;
                req_if.query_z <= nxt.query_z;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Accepted requests turn into expected answers
    always @(posedge i_clk) begin
        seg_req_t acc;
        req_taken = req_if.valid && req_if.ready;
        if (i_rst_n && req_taken) begin
            acc = '{req_if.start_x, req_if.start_y, req_if.start_z,
                    req_if.end_x, req_if.end_y, req_if.end_z,
                    req_if.query_x, req_if.query_y, req_if.query_z};
            nearest_expected.push_back(nearest_on_segment(acc));
            seg_sent++;
        end
    end

    // Result ready: random back-pressure plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= !hold_on &&
                            ($urandom_range(99) >= recv_idle_pct(nearest_seen));
        end
    end

    // Long hold-off, counted in cycles, so the pipeline fills and stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_on   <= 1'b0;
            hold_done <= 1'b0;
            hold_left <= 0;
        end else if (hold_on) begin
            if (hold_left == 0) begin
                hold_on   <= 1'b0;
                hold_done <= 1'b1;
            end else begin
                hold_left <= hold_left - 1;
            end
        end else if (!hold_done && nearest_seen >= HOLD_AT) begin
            hold_on   <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // Result monitor: compare against the oldest expected answer
    always @(posedge i_clk) begin
        seg_res_t got, want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.nearest_x, res_if.nearest_y, res_if.nearest_z,
                    res_if.param_t, res_if.degenerate};
            nearest_seen++;
            if (nearest_expected.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected result: nearest %h %h %h t %h degen %b",
                             got.nearest_x, got.nearest_y, got.nearest_z,
                             got.param_t, got.degenerate);
            end else begin
                want = nearest_expected.pop_front();
                if (got.nearest_x !== want.nearest_x || got.nearest_y !== want.nearest_y ||
                    got.nearest_z !== want.nearest_z || got.param_t !== want.param_t ||
                    got.degenerate !== want.degenerate) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("mismatch on result %0d:", nearest_seen);
                        $display("  got  nearest %h %h %h t %h degen %b",
                                 got.nearest_x, got.nearest_y, got.nearest_z,
                                 got.param_t, got.degenerate);
                        $display("  want nearest %h %h %h t %h degen %b",
                                 want.nearest_x, want.nearest_y, want.nearest_z,
                                 want.param_t, want.degenerate);
                    end
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        longint s [3];
        longint l [3];
        longint q [3];
        coord_t e [9];
        longint f;
        int     kind;

        // zero-length segments, including the extremes
        queue_seg('0, '0, '0, '0, '0, '0, '0, '0, '0);
        queue_seg(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
        queue_seg(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        // unit segment on x: midpoint, behind, beyond, at start, at end, perpendicular
        queue_seg('0, '0, '0, ONE_Q, '0, '0, ONE_Q / 2, '0, '0);
        queue_seg('0, '0, '0, ONE_Q, '0, '0, -ONE_Q, ONE_Q, '0);
        queue_seg('0, '0, '0, ONE_Q, '0, '0, 2 * ONE_Q, '0, -ONE_Q);
        queue_seg('0, '0, '0, ONE_Q, '0, '0, '0, '0, '0);
        queue_seg('0, '0, '0, ONE_Q, '0, '0, ONE_Q, '0, '0);
        queue_seg('0, '0, '0, ONE_Q, '0, '0, '0, 5 * ONE_Q, '0);
        // full-range diagonal segments
        queue_seg(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, '0, '0, '0);
        queue_seg(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        queue_seg(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        queue_seg(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
        queue_seg(C_MIN, C_MAX, '0, C_MAX, C_MIN, '1, C_MAX, C_MAX, C_MIN);
        // one-LSB lines: half steps truncate to zero offset, both signs
        queue_seg('0, '0, '0, 1, 1, '0, 1, '0, '0);
        queue_seg('0, '0, '0, '1, '1, '0, '1, '0, '0);
        queue_seg('0, '0, '0, 3, '0, '0, 1, '0, '0);
        queue_seg('1, '1, '1, '0, '0, '0, '0, '1, '1);
        queue_seg(C_MAX, '0, C_MIN, C_MAX - 7, 9, C_MIN + 5, C_MAX - 3, 4, C_MIN);
        queue_seg(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F,
                  32'hF0F0_F0F0, 32'h5555_AAAA, 32'hAAAA_5555,
                  32'h7654_3210, 32'h0123_4567, 32'hCAFE_0001);

        for (int n = 0; n < RAND_SEGS; n++) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                // query near an interior point of a moderate segment
                f = $urandom_range(ONE_Q);
                for (int a = 0; a < 3; a++) begin
                    s[a] = longint'($signed($urandom())) >>> 3;
                    l[a] = longint'($signed($urandom())) >>> 3;
                    q[a] = s[a] + (l[a] * f) / ONE_Q + (longint'($signed($urandom())) >>> 12);
                    e[a] = coord_t'(s[a]);
                    e[3 + a] = coord_t'(s[a] + l[a]);
                    e[6 + a] = coord_t'(q[a]);
                end
            end else if (kind < 60) begin
                for (int a = 0; a < 9; a++) e[a] = $urandom();
            end else if (kind < 70) begin
                // zero-length segment
                for (int a = 0; a < 3; a++) begin
                    e[a]     = ($urandom_range(1)) ? pick_special() : coord_t'($urandom());
                    e[3 + a] = e[a];
                    e[6 + a] = $urandom();
                end
            end else if (kind < 80) begin
                for (int a = 0; a < 9; a++) e[a] = pick_special();
            end else if (kind < 90) begin
                // query well behind start or past end
                f = $urandom_range(1) ? -longint'($urandom_range(4, 1)) * ONE_Q
                                      : longint'($urandom_range(5, 2)) * ONE_Q;
                for (int a = 0; a < 3; a++) begin
                    s[a] = longint'($signed($urandom())) >>> 3;
                    l[a] = longint'($signed($urandom())) >>> 5;
                    e[a] = coord_t'(s[a]);
                    e[3 + a] = coord_t'(s[a] + l[a]);
                    e[6 + a] = coord_t'(s[a] + (l[a] * f) / ONE_Q);
                end
            end else begin
                for (int a = 0; a < 9; a++)
                    e[a] = int'($urandom_range(2097152)) - 1048576;
            end
            queue_seg(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
        end

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (seg_pending.size() != 0 || req_if.valid) @(posedge i_clk);
        while (nearest_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
